@@ src/pcp_pkg.sv @@
`timescale 1ns / 1ps

package pcp_pkg;

    localparam int CAPACITY     = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int IDX_W        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam int ID_W   = 32;
    localparam int PRIO_W = 31;
    localparam int DATA_W = 32;

    localparam logic [PRIO_W-1:0] PRIO_MAX = {PRIO_W{1'b1}};
    localparam logic [ID_W-1:0]   ID_LAST  = {ID_W{1'b1}};

    typedef enum logic [2:0] {
        CMD_ADD      = 3'd0,
        CMD_IS_VALID = 3'd1,
        CMD_GET      = 3'd2,
        CMD_PROMOTE  = 3'd3,
        CMD_GET_MAX  = 3'd4,
        CMD_POP_MAX  = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    // write request into the slot table
    typedef struct packed {
        logic                    add_en;   // write a whole new entry, mark used
        logic                    prio_en;  // overwrite priority only
        logic                    clr_en;   // free the slot
        logic [IDX_W-1:0]        addr;
        logic [ID_W-1:0]         id;
        logic [PRIO_W-1:0]       prio;
        logic [PAYLOAD_BITS-1:0] payload;
    } wr_t;

    typedef struct packed {
        logic                    used;
        logic [ID_W-1:0]         id;
        logic [PRIO_W-1:0]       prio;
        logic [PAYLOAD_BITS-1:0] payload;
    } rd_t;

endpackage

@@ src/pcp_table.sv @@
`timescale 1ns / 1ps

module pcp_table (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [pcp_pkg::IDX_W-1:0]  rd_addr,
    output pcp_pkg::rd_t               rd,
    input  pcp_pkg::wr_t               wr
);
    import pcp_pkg::*;

    logic [CAPACITY-1:0]     used_reg;
    logic [ID_W-1:0]         id_mem   [CAPACITY];
    logic [PRIO_W-1:0]       prio_mem [CAPACITY];
    logic [PAYLOAD_BITS-1:0] pay_mem  [CAPACITY];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= '0;
        end else if (wr.add_en) begin
            used_reg[wr.addr] <= 1'b1;
        end else if (wr.clr_en) begin
            used_reg[wr.addr] <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.add_en) begin
            id_mem[wr.addr]  <= wr.id;
            pay_mem[wr.addr] <= wr.payload;
        end
        if (wr.add_en || wr.prio_en) begin
            prio_mem[wr.addr] <= wr.prio;
        end
    end

    assign rd.used    = used_reg[rd_addr];
    assign rd.id      = id_mem[rd_addr];
    assign rd.prio    = prio_mem[rd_addr];
    assign rd.payload = pay_mem[rd_addr];

endmodule

@@ src/priority_collection_with_promote.sv @@
`timescale 1ns / 1ps
// A request walks the slot table one slot per cycle through a single compare unit
// (id match, free slot, or {priority,id} max), then passes through a finish state.
// Add/lookup/promote stop at the first hit; max/pop always scan all CAPACITY slots.
// Unused codes skip the scan and go straight to the finish state.
// One request in flight; the next is taken once the previous result is registered.
// Reset (aresetn low, synchronous) frees all slots and clears the id counter.

module priority_collection_with_promote (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [71:0]   s_tdata,   // command[2:0], entry_id[34:3], payload_in[66:35]
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [103:0]  m_tdata    // status[1:0], found[2], id_out[34:3],
                                     // payload_out[66:35], priority_out[97:67]
);
    import pcp_pkg::*;

    state_t state_reg, state_next;

    logic [2:0]              cmd_reg, cmd_next;
    logic [ID_W-1:0]         qid_reg, qid_next;
    logic [PAYLOAD_BITS-1:0] pay_reg, pay_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [IDX_W-1:0]        sel_reg, sel_next;
    logic                    hit_reg, hit_next;
    logic [PRIO_W+ID_W-1:0]  best_reg, best_next;
    logic [ID_W-1:0]         ctr_reg, ctr_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [103:0]            m_tdata_reg, m_tdata_next;

    logic [IDX_W-1:0]        rd_addr;
    rd_t                     rd;
    wr_t                     wr;

    // shared compare unit
    logic                    id_eq;
    logic                    key_gt;
    logic                    scan_hit;
    logic                    scan_last;
    logic                    out_free;

    logic [1:0]              r_status;
    logic                    r_found;
    logic [ID_W-1:0]         r_id;
    logic [DATA_W-1:0]       r_payload;
    logic [PRIO_W-1:0]       r_prio;
    logic [PRIO_W-1:0]       prio_inc;
    logic [63:0]             pay_wide;
    logic [63:0]             in_pay_wide;

    pcp_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_addr (rd_addr),
        .rd      (rd),
        .wr      (wr)
    );

    assign rd_addr   = (state_reg == S_SCAN) ? idx_reg : sel_reg;
    assign id_eq     = (rd.id == qid_reg);
    assign key_gt    = ({rd.prio, rd.id} > best_reg);
    assign scan_last = (idx_reg == IDX_W'(CAPACITY - 1));
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb begin
        case (cmd_t'(cmd_reg))
            CMD_ADD:                  scan_hit = !rd.used;
            CMD_IS_VALID, CMD_GET,
            CMD_PROMOTE:              scan_hit = rd.used && id_eq;
            default:                  scan_hit = 1'b0;
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (s_tdata[2:0] <= 3'(CMD_POP_MAX)) begin
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_SCAN: begin
                if (scan_hit || scan_last) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign prio_inc    = (rd.prio == PRIO_MAX) ? rd.prio : rd.prio + PRIO_W'(1);
    assign pay_wide    = 64'(rd.payload);
    assign in_pay_wide = 64'(s_tdata[66:35]);

    // result fields for the finish cycle
    always_comb begin
        r_status  = ST_OK;
        r_found   = 1'b0;
        r_id      = '0;
        r_payload = '0;
        r_prio    = '0;
        case (cmd_t'(cmd_reg))
            CMD_ADD: begin
                if (!hit_reg || ctr_reg == ID_LAST) begin
                    r_status = ST_FULL;
                end else begin
                    r_found = 1'b1;
                    r_id    = ctr_reg + ID_W'(1);
                end
            end
            CMD_IS_VALID: begin
                r_found = hit_reg;
                r_id    = qid_reg;
            end
            CMD_GET, CMD_PROMOTE: begin
                r_id = qid_reg;
                if (!hit_reg) begin
                    r_status = ST_NOT_FOUND;
                end else begin
                    r_found   = 1'b1;
                    r_payload = pay_wide[DATA_W-1:0];
                    r_prio    = (cmd_t'(cmd_reg) == CMD_PROMOTE) ? prio_inc : rd.prio;
                end
            end
            CMD_GET_MAX, CMD_POP_MAX: begin
                if (!hit_reg) begin
                    r_status = ST_EMPTY;
                end else begin
                    r_found   = 1'b1;
                    r_id      = rd.id;
                    r_payload = pay_wide[DATA_W-1:0];
                    r_prio    = rd.prio;
                end
            end
            default: ;
        endcase
    end

    // datapath and outputs
    always_comb begin
        cmd_next      = cmd_reg;
        qid_next      = qid_reg;
        pay_next      = pay_reg;
        idx_next      = idx_reg;
        sel_next      = sel_reg;
        hit_next      = hit_reg;
        best_next     = best_reg;
        ctr_next      = ctr_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        wr         = '0;
        wr.addr    = sel_reg;
        wr.id      = ctr_reg + ID_W'(1);
        wr.prio    = '0;
        wr.payload = pay_reg;

        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd_next  = s_tdata[2:0];
                    qid_next  = s_tdata[34:3];
                    pay_next  = in_pay_wide[PAYLOAD_BITS-1:0];
                    idx_next  = '0;
                    hit_next  = 1'b0;
                    best_next = '0;
                end
            end
            S_SCAN: begin
                idx_next = idx_reg + IDX_W'(1);
                if (cmd_t'(cmd_reg) == CMD_GET_MAX || cmd_t'(cmd_reg) == CMD_POP_MAX) begin
                    if (rd.used && (!hit_reg || key_gt)) begin
                        hit_next  = 1'b1;
                        sel_next  = idx_reg;
                        best_next = {rd.prio, rd.id};
                    end
                end else if (scan_hit) begin
                    hit_next = 1'b1;
                    sel_next = idx_reg;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {6'b0, r_prio, r_payload, r_id, r_found, r_status};
                    case (cmd_t'(cmd_reg))
                        CMD_ADD: begin
                            if (hit_reg && ctr_reg != ID_LAST) begin
                                wr.add_en = 1'b1;
                                ctr_next  = ctr_reg + ID_W'(1);
                            end
                        end
                        CMD_PROMOTE: begin
                            wr.prio_en = hit_reg;
                            wr.prio    = prio_inc;
                        end
                        CMD_POP_MAX: begin
                            wr.clr_en = hit_reg;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            ctr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            hit_reg      <= 1'b0;
            idx_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            ctr_reg      <= ctr_next;
            m_tvalid_reg <= m_tvalid_next;
            hit_reg      <= hit_next;
            idx_reg      <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        qid_reg     <= qid_next;
        pay_reg     <= pay_next;
        sel_reg     <= sel_next;
        best_reg    <= best_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import pcp_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RANDOM_ITEMS = 1780;
    localparam int PHASE_LEN    = 120;
    localparam int QUIET_ITEMS  = 250;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 150;
    localparam int DIRECTED_N   = 23;
    localparam int PRINT_CAP    = 50;

    // codes with no command behind them
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    // fields from the highest bit down, same order as s_tdata
    typedef struct packed {
        logic [DATA_W-1:0] payload;
        logic [ID_W-1:0]   id;
        logic [2:0]        cmd;
    } request_t;

    // fields from the highest bit down, same order as m_tdata[97:0]
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [DATA_W-1:0] payload;
        logic [ID_W-1:0]   id;
        logic              found;
        status_t           status;
    } reply_t;

    typedef struct {
        request_t rq;
        bit       typed;
        reply_t   want;
    } opening_row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [71:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;

    priority_collection_with_promote dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // shadow copy of the slot table
    logic              sh_used    [CAPACITY];
    logic [ID_W-1:0]   sh_id      [CAPACITY];
    logic [PRIO_W-1:0] sh_prio    [CAPACITY];
    logic [DATA_W-1:0] sh_payload [CAPACITY];
    logic [ID_W-1:0]   sh_counter;
    logic [ID_W-1:0]   sh_last_gone;

    reply_t replies_due[$];

    int  errors;
    int  requests_sent;
    int  replies_checked;
    int  full_adds;
    int  empty_reads;
    int  unknown_ids;
    bit  quiet;
    bit  held;
    int  hold_left;
    int  stall_left;

    opening_row_t opening_requests [DIRECTED_N] = '{
        '{'{32'h0, 32'h0, CMD_GET_MAX}, 1'b1, '{31'h0, 32'h0, 32'h0, 1'b0, ST_EMPTY}},
        '{'{32'h0, ID_LAST, CMD_POP_MAX}, 1'b1, '{31'h0, 32'h0, 32'h0, 1'b0, ST_EMPTY}},
        '{'{32'h0, 32'h0, CMD_IS_VALID}, 1'b1, '{31'h0, 32'h0, 32'h0, 1'b0, ST_OK}},
        '{'{32'h0, ID_LAST, CMD_IS_VALID}, 1'b1, '{31'h0, 32'h0, ID_LAST, 1'b0, ST_OK}},
        '{'{32'h0, ID_LAST, CMD_GET}, 1'b1, '{31'h0, 32'h0, ID_LAST, 1'b0, ST_NOT_FOUND}},
        '{'{32'h0, 32'h1, CMD_PROMOTE}, 1'b1, '{31'h0, 32'h0, 32'h1, 1'b0, ST_NOT_FOUND}},
        '{'{32'hFFFF_FFFF, ID_LAST, CMD_SPARE_6}, 1'b1, '{31'h0, 32'h0, 32'h0, 1'b0, ST_OK}},
        '{'{32'hFFFF_FFFF, ID_LAST, CMD_SPARE_7}, 1'b1, '{31'h0, 32'h0, 32'h0, 1'b0, ST_OK}},
        '{'{32'hFFFF_FFFF, ID_LAST, CMD_ADD}, 1'b1, '{31'h0, 32'h0, 32'h1, 1'b1, ST_OK}},
        '{'{32'h0, 32'h0, CMD_ADD}, 1'b1, '{31'h0, 32'h0, 32'h2, 1'b1, ST_OK}},
        '{'{32'h5A5A_A5A5, 32'h0, CMD_ADD}, 1'b1, '{31'h0, 32'h0, 32'h3, 1'b1, ST_OK}},
        '{'{32'h0, 32'h0, CMD_GET_MAX}, 1'b0, '0},
        '{'{32'h0, 32'h1, CMD_PROMOTE}, 1'b0, '0},
        '{'{32'h0, 32'h1, CMD_PROMOTE}, 1'b0, '0},
        '{'{32'h0, 32'h2, CMD_PROMOTE}, 1'b0, '0},
        '{'{32'h0, 32'h1, CMD_GET}, 1'b0, '0},
        '{'{32'h0, 32'h2, CMD_IS_VALID}, 1'b1, '{31'h0, 32'h0, 32'h2, 1'b1, ST_OK}},
        '{'{32'h0, 32'h0, CMD_POP_MAX}, 1'b0, '0},
        '{'{32'h0, 32'h1, CMD_GET}, 1'b1, '{31'h0, 32'h0, 32'h1, 1'b0, ST_NOT_FOUND}},
        '{'{32'h0, 32'h3, CMD_PROMOTE}, 1'b0, '0},
        '{'{32'h0, 32'h0, CMD_POP_MAX}, 1'b0, '0},
        '{'{32'h0, 32'h0, CMD_POP_MAX}, 1'b0, '0},
        '{'{32'h0, 32'h0, CMD_POP_MAX}, 1'b1, '{31'h0, 32'h0, 32'h0, 1'b0, ST_EMPTY}}
    };

    initial aclk = 1'b0;
    always #(CLK_PERIOD / 2) aclk = ~aclk;

    task automatic flag_error(input string msg);
        if (errors < PRINT_CAP)
            $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic int locate_id(input logic [ID_W-1:0] id);
        for (int i = 0; i < CAPACITY; i++)
            if (sh_used[i] && sh_id[i] == id)
                return i;
        return -1;
    endfunction

    function automatic reply_t shadow_execute(input request_t rq);
        reply_t r;
        int     hit;
        r   = '0;
        hit = -1;
        case (rq.cmd)
            CMD_ADD: begin
                for (int i = CAPACITY - 1; i >= 0; i--)
                    if (!sh_used[i])
                        hit = i;
                if (hit < 0 || sh_counter == ID_LAST) begin
                    r.status = ST_FULL;
                end else begin
                    sh_counter       = sh_counter + ID_W'(1);
                    sh_used[hit]     = 1'b1;
                    sh_id[hit]       = sh_counter;
                    sh_prio[hit]     = '0;
                    sh_payload[hit]  = rq.payload;
                    r.found          = 1'b1;
                    r.id             = sh_counter;
                end
            end
            CMD_IS_VALID: begin
                r.found = (locate_id(rq.id) >= 0);
                r.id    = rq.id;
            end
            CMD_GET, CMD_PROMOTE: begin
                hit = locate_id(rq.id);
                if (hit < 0) begin
                    r.status = ST_NOT_FOUND;
                    r.id     = rq.id;
                end else begin
                    if (rq.cmd == CMD_PROMOTE && sh_prio[hit] != PRIO_MAX)
                        sh_prio[hit] = sh_prio[hit] + PRIO_W'(1);
                    r.found   = 1'b1;
                    r.id      = sh_id[hit];
                    r.payload = sh_payload[hit];
                    r.prio    = sh_prio[hit];
                end
            end
            CMD_GET_MAX, CMD_POP_MAX: begin
                for (int i = 0; i < CAPACITY; i++)
                    if (sh_used[i] && (hit < 0 || sh_prio[i] > sh_prio[hit] ||
                        (sh_prio[i] == sh_prio[hit] && sh_id[i] > sh_id[hit])))
                        hit = i;
                if (hit < 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.found   = 1'b1;
                    r.id      = sh_id[hit];
                    r.payload = sh_payload[hit];
                    r.prio    = sh_prio[hit];
                    if (rq.cmd == CMD_POP_MAX) begin
                        sh_used[hit] = 1'b0;
                        sh_last_gone = sh_id[hit];
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // mostly live ids, then retired, not-yet-issued and arbitrary ones
    function automatic logic [ID_W-1:0] pick_id();
        int r;
        int s;
        r = $urandom_range(0, 99);
        s = $urandom_range(0, CAPACITY - 1);
        if (r < 70) begin
            for (int k = 0; k < CAPACITY; k++)
                if (sh_used[(s + k) % CAPACITY])
                    return sh_id[(s + k) % CAPACITY];
            return sh_counter + ID_W'(1);
        end
        if (r < 80)
            return sh_last_gone;
        if (r < 85)
            return sh_counter + ID_W'(1);
        if (r < 95)
            return $urandom;
        return r[0] ? ID_LAST : '0;
    endfunction

    // even phases grow the table toward full, odd phases drain it
    function automatic logic [2:0] pick_cmd(input bit draining);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return $urandom_range(0, 1) ? CMD_SPARE_7 : CMD_SPARE_6;
        if (r < 13)
            return CMD_IS_VALID;
        if (r < 25)
            return CMD_GET;
        if (r < 45)
            return CMD_PROMOTE;
        if (r < (draining ? 53 : 50))
            return CMD_GET_MAX;
        if (r < (draining ? 85 : 55))
            return CMD_POP_MAX;
        return CMD_ADD;
    endfunction

    task automatic send_request(input request_t rq, input bit typed, input reply_t typed_reply);
        reply_t due;
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, rq};
        do @(posedge aclk); while (!s_tready);
        due = shadow_execute(rq);
        if (typed)
            due = typed_reply;
        case (due.status)
            ST_FULL:      full_adds++;
            ST_EMPTY:     empty_reads++;
            ST_NOT_FOUND: unknown_ids++;
            default: ;
        endcase
        replies_due.push_back(due);
        requests_sent++;
    endtask

    task automatic maybe_pause();
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
    endtask

    task automatic check_reply(input logic [103:0] word);
        reply_t got;
        reply_t want;
        got = reply_t'(word[97:0]);
        if (replies_due.size() == 0) begin
            flag_error($sformatf("reply with no request outstanding: %h", word));
        end else begin
            want = replies_due.pop_front();
            if (got.status !== want.status)
                flag_error($sformatf("reply %0d status %0d, want %0d",
                    replies_checked, got.status, want.status));
            if (got.found !== want.found)
                flag_error($sformatf("reply %0d found %b, want %b",
                    replies_checked, got.found, want.found));
            if (got.id !== want.id)
                flag_error($sformatf("reply %0d id %h, want %h",
                    replies_checked, got.id, want.id));
            if (got.payload !== want.payload)
                flag_error($sformatf("reply %0d payload %h, want %h",
                    replies_checked, got.payload, want.payload));
            if (got.prio !== want.prio)
                flag_error($sformatf("reply %0d priority %h, want %h",
                    replies_checked, got.prio, want.prio));
        end
        replies_checked++;
    endtask

    // result side: random stalls plus one long hold-off so requests back up
    initial begin
        m_tready   <= 1'b0;
        hold_left  = 0;
        stall_left = 0;
        held       = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (m_tvalid && m_tready)
                check_reply(m_tdata);
            if (!held && replies_checked >= HOLD_AT) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left == 0 && stall_left == 0 && !quiet && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 7);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
            @(posedge aclk);
        end
    end

    initial begin
        #(CLK_PERIOD * 400000);
        $display("tb NOT OK");
        $finish;
    end

    initial begin
        request_t rq;
        int       drain_wait;
        errors          = 0;
        requests_sent   = 0;
        replies_checked = 0;
        full_adds       = 0;
        empty_reads     = 0;
        unknown_ids     = 0;
        quiet           = 1'b0;
        sh_counter      = '0;
        sh_last_gone    = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            sh_used[i]    = 1'b0;
            sh_id[i]      = '0;
            sh_prio[i]    = '0;
            sh_payload[i] = '0;
        end
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (opening_requests[i]) begin
            send_request(opening_requests[i].rq, opening_requests[i].typed,
                         opening_requests[i].want);
            maybe_pause();
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            quiet      = (n >= RANDOM_ITEMS - QUIET_ITEMS);
            rq.cmd     = pick_cmd((n / PHASE_LEN) % 2 == 1);
            rq.id      = (rq.cmd == CMD_IS_VALID || rq.cmd == CMD_GET ||
                          rq.cmd == CMD_PROMOTE) ? pick_id() : $urandom;
            rq.payload = ($urandom_range(0, 15) == 0) ?
                         ($urandom_range(0, 1) ? '1 : '0) : $urandom;
            send_request(rq, 1'b0, '0);
            maybe_pause();
        end
        s_tvalid <= 1'b0;

        drain_wait = 0;
        while (replies_due.size() != 0 && drain_wait < 100000) begin
            @(posedge aclk);
            drain_wait++;
        end
        if (replies_due.size() != 0)
            flag_error($sformatf("%0d replies never arrived", replies_due.size()));
        // late extra replies would show up within one full scan
        repeat (CAPACITY + 8) @(posedge aclk);

        $display("tb: %0d requests, %0d replies checked, %0d errors",
                 requests_sent, replies_checked, errors);
        $display("tb: adds refused on full table %0d, empty max/pop %0d, unknown ids %0d",
                 full_adds, empty_reads, unknown_ids);
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
